>>> design/sbsh_pkg.sv
// Package for the segment/box slab hit unit: shared widths, constants and
// the structs that pass between the top level and the fold stages.
`default_nettype none
package sbsh_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int AXES           = 3;
  localparam int THR_W          = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd1;

  // Slab parameters carry 16 fraction bits and 2 integer bits of quotient.
  localparam int T_FRAC  = 16;
  localparam int QB      = T_FRAC + 2;
  localparam int T_W     = T_FRAC + 3;
  localparam int DIV_LAT = QB + 2;

  localparam logic signed [T_W-1:0] T_ONE  = T_W'(1) <<< T_FRAC;
  localparam logic signed [T_W-1:0] T_LOW  = -(T_W'(1) <<< T_FRAC);
  localparam logic signed [T_W-1:0] T_HIGH = T_W'(2) <<< T_FRAC;
  localparam logic [15:0] ENTRY_MAX = 16'hFFFF;

  typedef struct packed {
    logic par;
    logic pmiss;
    logic swap;
  } side_t;

  typedef struct packed {
    logic                    par;
    logic                    pmiss;
    logic                    swap;
    logic signed [T_W-1:0]   t1;
    logic signed [T_W-1:0]   t2;
  } slab_t;

  typedef struct packed {
    logic                    miss;
    logic signed [T_W-1:0]   tmin;
    logic signed [T_W-1:0]   tmax;
    logic [1:0]              axis;
    logic                    pos;
  } fold_t;

endpackage
`default_nettype wire

>>> design/sbsh_div_step.sv
// One restoring division step: a trial subtract of the shifted divisor.
// Uses no package items.
`default_nettype none
module sbsh_div_step #(
  parameter int CW    = 32,
  parameter int W     = 50,
  parameter int QBITS = 18,
  parameter int SHIFT = 17
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [W-1:0]     r_i,
  input  wire logic [QBITS-1:0] q_i,
  input  wire logic [CW-1:0]    ud_i,
  input  wire logic             neg_i,
  input  wire logic             ovf_i,
  output logic [W-1:0]          r_o,
  output logic [QBITS-1:0]      q_o,
  output logic [CW-1:0]         ud_o,
  output logic                  neg_o,
  output logic                  ovf_o
);

  logic [W-1:0]     dsh;
  logic             ge;
  logic [W-1:0]     r_d;
  logic [QBITS-1:0] q_d;

  always_comb begin
    dsh = W'(ud_i) << SHIFT;
    ge  = (r_i >= dsh);
    r_d = ge ? (r_i - dsh) : r_i;
    q_d = q_i;
    q_d[SHIFT] = ge;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o   <= r_d;
      q_o   <= q_d;
      ud_o  <= ud_i;
      neg_o <= neg_i;
      ovf_o <= ovf_i;
    end
  end

endmodule
`default_nettype wire

>>> design/sbsh_divider.sv
// Pipelined floor divider for slab parameters, saturated to [-1, 2].
// Depends on sbsh_pkg and sbsh_div_step.
`default_nettype none
module sbsh_divider #(
  parameter int CW = sbsh_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [CW-1:0]                un_i,
  input  wire logic [CW-1:0]                ud_i,
  input  wire logic                         neg_i,
  output logic signed [sbsh_pkg::T_W-1:0]   t_o
);

  localparam int QBITS = sbsh_pkg::QB;
  localparam int W     = CW + QBITS;
  localparam int TW    = sbsh_pkg::T_W;

  logic [W-1:0]     r   [QBITS+1];
  logic [QBITS-1:0] q   [QBITS+1];
  logic [CW-1:0]    ud  [QBITS+1];
  logic             neg [QBITS+1];
  logic             ovf [QBITS+1];

  logic [CW+1:0] ud3;
  assign ud3 = (CW+2)'(ud_i) + ((CW+2)'(ud_i) << 1);

  // A quotient of three or more saturates, so only 18 quotient bits are formed.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r[0]   <= W'(un_i) << sbsh_pkg::T_FRAC;
      q[0]   <= '0;
      ud[0]  <= ud_i;
      neg[0] <= neg_i;
      ovf[0] <= ((CW+2)'(un_i) >= ud3);
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    sbsh_div_step #(
      .CW(CW), .W(W), .QBITS(QBITS), .SHIFT(QBITS-1-k)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en_i),
      .r_i   (r[k]),
      .q_i   (q[k]),
      .ud_i  (ud[k]),
      .neg_i (neg[k]),
      .ovf_i (ovf[k]),
      .r_o   (r[k+1]),
      .q_o   (q[k+1]),
      .ud_o  (ud[k+1]),
      .neg_o (neg[k+1]),
      .ovf_o (ovf[k+1])
    );
  end

  logic [TW-1:0]        qn;
  logic signed [TW-1:0] t_d;

  always_comb begin
    qn = TW'(q[QBITS]) + TW'(r[QBITS] != '0);
    if (ovf[QBITS]) begin
      t_d = neg[QBITS] ? sbsh_pkg::T_LOW : sbsh_pkg::T_HIGH;
    end else if (neg[QBITS]) begin
      t_d = (qn > TW'(sbsh_pkg::T_ONE)) ? sbsh_pkg::T_LOW : -$signed(qn);
    end else begin
      t_d = (TW'(q[QBITS]) > TW'(sbsh_pkg::T_HIGH)) ? sbsh_pkg::T_HIGH
                                                     : $signed(TW'(q[QBITS]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_o <= t_d;
    end
  end

endmodule
`default_nettype wire

>>> design/sbsh_fold.sv
// One fold stage: merges the slab of one axis into the running interval.
// Depends on sbsh_pkg.
`default_nettype none
module sbsh_fold #(
  parameter int AXIS = 0
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  valid_i,
  input  wire sbsh_pkg::fold_t                       st_i,
  input  wire sbsh_pkg::slab_t [sbsh_pkg::AXES-1:0]  sl_i,
  output logic                                       valid_o,
  output sbsh_pkg::fold_t                            st_o,
  output sbsh_pkg::slab_t [sbsh_pkg::AXES-1:0]       sl_o
);

  sbsh_pkg::slab_t s;
  sbsh_pkg::fold_t st_d;
  logic signed [sbsh_pkg::T_W-1:0] t1, t2;

  always_comb begin
    s    = sl_i[AXIS];
    t1   = s.swap ? $signed(s.t2) : $signed(s.t1);
    t2   = s.swap ? $signed(s.t1) : $signed(s.t2);
    st_d = st_i;
    if (s.par) begin
      st_d.miss = st_i.miss | s.pmiss;
    end else begin
      if (t1 > $signed(st_i.tmin)) begin
        st_d.tmin = t1;
        st_d.axis = 2'(AXIS);
        st_d.pos  = s.swap;
      end
      if (t2 < $signed(st_i.tmax)) begin
        st_d.tmax = t2;
      end
      if ($signed(st_d.tmin) > $signed(st_d.tmax)) begin
        st_d.miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_o <= st_d;
      sl_o <= sl_i;
    end
  end

endmodule
`default_nettype wire

>>> design/segment_box_slab_hit_unit.sv
// Segment versus axis-aligned box slab test, one item per cycle unless the output
// stalls. An item takes 2 input stages, 20 divider stages (six lanes of an 18-step
// restoring divider, one quotient bit per step), 3 fold stages and an output
// register. A stall on the output freezes the whole pipeline; items never drop
// or repeat. Threshold writes are registered and are not held by a stall.
`default_nettype none
module segment_box_slab_hit_unit #(
  parameter int COORD_BITS = sbsh_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sbsh_pkg::THR_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]  start_x_i,
  input  wire logic signed [COORD_BITS-1:0]  start_y_i,
  input  wire logic signed [COORD_BITS-1:0]  start_z_i,
  input  wire logic signed [COORD_BITS-1:0]  end_x_i,
  input  wire logic signed [COORD_BITS-1:0]  end_y_i,
  input  wire logic signed [COORD_BITS-1:0]  end_z_i,
  input  wire logic signed [COORD_BITS-1:0]  box_min_x_i,
  input  wire logic signed [COORD_BITS-1:0]  box_min_y_i,
  input  wire logic signed [COORD_BITS-1:0]  box_min_z_i,
  input  wire logic signed [COORD_BITS-1:0]  box_max_x_i,
  input  wire logic signed [COORD_BITS-1:0]  box_max_y_i,
  input  wire logic signed [COORD_BITS-1:0]  box_max_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               hit_o,
  output logic [15:0]                        entry_param_o,
  output logic [1:0]                         face_axis_o,
  output logic                               face_positive_o
);

  localparam int C    = COORD_BITS;
  localparam int NA   = sbsh_pkg::AXES;
  localparam int LAT  = sbsh_pkg::DIV_LAT;
  localparam int TW   = sbsh_pkg::T_W;

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic [sbsh_pkg::THR_W-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= sbsh_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  logic signed [C-1:0] s_in [NA], e_in [NA], lo_in [NA], hi_in [NA];
  assign s_in  = '{start_x_i, start_y_i, start_z_i};
  assign e_in  = '{end_x_i, end_y_i, end_z_i};
  assign lo_in = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign hi_in = '{box_max_x_i, box_max_y_i, box_max_z_i};

  // Stage A: differences and the comparisons that need the raw coordinates.
  logic va_q, vb_q;
  logic signed [C:0] da_q [NA], n1a_q [NA], n2a_q [NA];
  logic              pmissa_q [NA], swapa_q [NA];
  // Stage B: magnitudes and signs for the divider lanes.
  logic [C-1:0]      mda_q [NA], mn1_q [NA], mn2_q [NA];
  logic              neg1_q [NA], neg2_q [NA];
  sbsh_pkg::side_t [NA-1:0] sideb_q;

  function automatic logic [C-1:0] mag(input logic signed [C:0] v);
    logic signed [C:0] a;
    a = (v < 0) ? -v : v;
    return a[C-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
    end
  end

  for (genvar a = 0; a < NA; a++) begin : g_front
    always_ff @(posedge clk_i) begin
      if (en) begin
        da_q[a]     <= (C+1)'(e_in[a]) - (C+1)'(s_in[a]);
        n1a_q[a]    <= (C+1)'(lo_in[a]) - (C+1)'(s_in[a]);
        n2a_q[a]    <= (C+1)'(hi_in[a]) - (C+1)'(s_in[a]);
        pmissa_q[a] <= (s_in[a] <= lo_in[a]) || (s_in[a] >= hi_in[a]);
        swapa_q[a]  <= (e_in[a] > s_in[a]) ? (lo_in[a] > hi_in[a])
                                           : (lo_in[a] < hi_in[a]);
        mda_q[a]    <= mag(da_q[a]);
        mn1_q[a]    <= mag(n1a_q[a]);
        mn2_q[a]    <= mag(n2a_q[a]);
        neg1_q[a]   <= (n1a_q[a] < 0) != (da_q[a] < 0);
        neg2_q[a]   <= (n2a_q[a] < 0) != (da_q[a] < 0);
        sideb_q[a].par   <= (da_q[a] == '0) ||
                            ((C+1)'(mag(da_q[a])) < (C+1)'(thr_q));
        sideb_q[a].pmiss <= pmissa_q[a];
        sideb_q[a].swap  <= swapa_q[a];
      end
    end
  end

  // Divider lanes with the per-axis flags delayed alongside.
  logic signed [TW-1:0] t1_w [NA], t2_w [NA];
  sbsh_pkg::side_t [NA-1:0] side_q [LAT];
  logic [LAT-1:0] vdiv_q;

  for (genvar a = 0; a < NA; a++) begin : g_lane
    sbsh_divider #(.CW(C)) u_div1 (
      .clk_i(clk_i), .en_i(en), .un_i(mn1_q[a]), .ud_i(mda_q[a]),
      .neg_i(neg1_q[a]), .t_o(t1_w[a])
    );
    sbsh_divider #(.CW(C)) u_div2 (
      .clk_i(clk_i), .en_i(en), .un_i(mn2_q[a]), .ud_i(mda_q[a]),
      .neg_i(neg2_q[a]), .t_o(t2_w[a])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdiv_q <= '0;
    end else if (en) begin
      vdiv_q <= {vdiv_q[LAT-2:0], vb_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= sideb_q;
      for (int k = 1; k < LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  sbsh_pkg::slab_t [NA-1:0] slab0;
  sbsh_pkg::fold_t          st0;
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      slab0[a].par   = side_q[LAT-1][a].par;
      slab0[a].pmiss = side_q[LAT-1][a].pmiss;
      slab0[a].swap  = side_q[LAT-1][a].swap;
      slab0[a].t1    = t1_w[a];
      slab0[a].t2    = t2_w[a];
    end
    st0.miss = 1'b0;
    st0.tmin = '0;
    st0.tmax = sbsh_pkg::T_ONE;
    st0.axis = 2'd0;
    st0.pos  = 1'b0;
  end

  logic                     vf [NA+1];
  sbsh_pkg::fold_t          stf [NA+1];
  sbsh_pkg::slab_t [NA-1:0] slf [NA+1];
  assign vf[0]  = vdiv_q[LAT-1];
  assign stf[0] = st0;
  assign slf[0] = slab0;

  for (genvar a = 0; a < NA; a++) begin : g_fold
    sbsh_fold #(.AXIS(a)) u_fold (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
      .valid_i(vf[a]), .st_i(stf[a]), .sl_i(slf[a]),
      .valid_o(vf[a+1]), .st_o(stf[a+1]), .sl_o(slf[a+1])
    );
  end

  // Output register; a start inside the box leaves tmin at zero and misses.
  sbsh_pkg::fold_t fin;
  logic            hit_d;
  assign fin   = stf[NA];
  assign hit_d = !fin.miss && ($signed(fin.tmin) > 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vf[NA];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o           <= hit_d;
      entry_param_o   <= !hit_d ? 16'd0 :
                         (fin.tmin > TW'(sbsh_pkg::ENTRY_MAX)) ? sbsh_pkg::ENTRY_MAX
                                                               : fin.tmin[15:0];
      face_axis_o     <= hit_d ? fin.axis : 2'd0;
      face_positive_o <= hit_d ? fin.pos : 1'b0;
    end
  end

  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (entry_param_o != 16'd0))
    else $error("hit reported with zero entry parameter");

  a_miss_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (entry_param_o == 16'd0 && face_axis_o == 2'd0
                                 && !face_positive_o))
    else $error("miss reported with nonzero face data");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (face_axis_o != 2'd3))
    else $error("face axis out of range");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> va_q)
    else $error("accepted transfer did not enter the first stage");

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for segment_box_slab_hit_unit: random and directed segment/box pairs
// are checked against a slab-test scoreboard. Depends on sbsh_pkg and the unit.

typedef struct {
  int s[3];
  int e[3];
  int lo[3];
  int hi[3];
} seg_box_t;

typedef struct packed {
  bit        hit;
  bit [15:0] entry;
  bit [1:0]  axis;
  bit        pos;
} hit_result_t;

class hit_scoreboard;
  hit_result_t expected_hits[$];
  longint      threshold = 1;
  int          errors = 0;

  // Floor quotient with 16 fraction bits, saturated to [-1.0, 2.0].
  function automatic longint slab_quot(longint n, longint d);
    longint un, ud, f, r;
    bit     neg;
    un  = (n < 0) ? -n : n;
    ud  = (d < 0) ? -d : d;
    neg = (n < 0) != (d < 0);
    if (un / ud >= 3) return neg ? -65536 : 131072;
    f = (un <<< 16) / ud;
    r = (un <<< 16) % ud;
    if (neg) f = -(f + ((r != 0) ? 1 : 0));
    if (f < -65536) f = -65536;
    if (f > 131072) f = 131072;
    return f;
  endfunction

  function automatic hit_result_t slab_hit(seg_box_t it);
    hit_result_t res;
    longint      tmin, tmax, s, e, lo, hi, d, t1, t2, tt;
    bit          miss, swap;
    bit [1:0]    ax;
    bit          ps;
    tmin = 0;
    tmax = 65536;
    miss = 0;
    ax   = 0;
    ps   = 0;
    for (int i = 0; i < 3 && !miss; i++) begin
      s  = it.s[i];
      e  = it.e[i];
      lo = it.lo[i];
      hi = it.hi[i];
      d  = e - s;
      if (d == 0 || ((d < 0) ? -d : d) < threshold) begin
        if (s <= lo || s >= hi) miss = 1;
      end else begin
        t1   = slab_quot(lo - s, d);
        t2   = slab_quot(hi - s, d);
        swap = (d > 0) ? (lo > hi) : (lo < hi);
        if (swap) begin
          tt = t1;
          t1 = t2;
          t2 = tt;
        end
        if (t1 > tmin) begin
          tmin = t1;
          ax   = 2'(i);
          ps   = swap;
        end
        if (t2 < tmax) tmax = t2;
        if (tmin > tmax) miss = 1;
      end
    end
    res = '{default: 0};
    if (!miss && tmin > 0) begin
      res.hit   = 1;
      res.entry = (tmin > 65535) ? 16'hFFFF : tmin[15:0];
      res.axis  = ax;
      res.pos   = ps;
    end
    return res;
  endfunction

  function void note_input(seg_box_t it);
    expected_hits.push_back(slab_hit(it));
  endfunction

  function void check_result(hit_result_t got);
    hit_result_t want;
    if (expected_hits.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result transfer: hit %0d entry %0h", got.hit,
                                 got.entry);
      return;
    end
    want = expected_hits.pop_front();
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp hit %0d entry %0h axis %0d pos %0d, got %0d %0h %0d %0d",
                 want.hit, want.entry, want.axis, want.pos,
                 got.hit, got.entry, got.axis, got.pos);
    end
  endfunction
endclass

module tb_top;

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              cfg_we_i = 0;
  logic [sbsh_pkg::THR_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 0;
  logic              in_stall_o;
  logic signed [31:0] st[3], en[3], bmin[3], bmax[3];
  logic              out_valid_o;
  logic              out_stall_i = 0;
  logic              hit_o;
  logic [15:0]       entry_param_o;
  logic [1:0]        face_axis_o;
  logic              face_positive_o;

  hit_scoreboard sb = new();
  int            stall_mode = 0;
  int            stall_left = 0;

  initial begin
    for (int i = 0; i < 3; i++) begin
      st[i] = 0; en[i] = 0; bmin[i] = 0; bmax[i] = 0;
    end
  end

  segment_box_slab_hit_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .start_x_i(st[0]), .start_y_i(st[1]), .start_z_i(st[2]),
    .end_x_i(en[0]), .end_y_i(en[1]), .end_z_i(en[2]),
    .box_min_x_i(bmin[0]), .box_min_y_i(bmin[1]), .box_min_z_i(bmin[2]),
    .box_max_x_i(bmax[0]), .box_max_y_i(bmax[1]), .box_max_z_i(bmax[2]),
    .out_valid_o, .out_stall_i, .hit_o, .entry_param_o, .face_axis_o, .face_positive_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  // The receiver alternates between free running, light and heavy stalling.
  always @(posedge clk_i) begin
    hit_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.hit   = hit_o;
      got.entry = entry_param_o;
      got.axis  = face_axis_o;
      got.pos   = face_positive_o;
      sb.check_result(got);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic send_item(seg_box_t it);
    for (int i = 0; i < 3; i++) begin
      st[i]   <= it.s[i];
      en[i]   <= it.e[i];
      bmin[i] <= it.lo[i];
      bmax[i] <= it.hi[i];
    end
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Threshold changes only on an empty pipeline.
  task automatic write_threshold(int value);
    in_valid_i <= 0;
    while (sb.expected_hits.size() != 0) @(posedge clk_i);
    repeat (sbsh_pkg::DIV_LAT + 10) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= value[sbsh_pkg::THR_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.threshold = value & 16'hFFFF;
  endtask

  function automatic seg_box_t random_item();
    seg_box_t it;
    int       c, h, k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (k < 2) begin
        it.s[i] = $urandom; it.e[i] = $urandom; it.lo[i] = $urandom; it.hi[i] = $urandom;
      end else begin
        c = $urandom_range(0, 1 << 21) - (1 << 20);
        h = $urandom_range(1, 1 << 18);
        it.lo[i] = c - h;
        it.hi[i] = c + h;
        if ($urandom_range(0, 19) == 0) begin
          it.lo[i] = c + h;
          it.hi[i] = c - h;
        end
        it.s[i] = c + $urandom_range(0, 1 << 20) - (1 << 19);
        case ($urandom_range(0, 9))
          0: it.e[i] = it.s[i];
          1: it.e[i] = it.s[i] + $urandom_range(0, 200) - 100;
          default: it.e[i] = c + $urandom_range(0, 1 << 20) - (1 << 19);
        endcase
      end
    end
    return it;
  endfunction

  function automatic seg_box_t box_item(int sx, int ex, int lo, int hi);
    seg_box_t it;
    for (int i = 0; i < 3; i++) begin
      it.s[i] = 0; it.e[i] = 0; it.lo[i] = -100; it.hi[i] = 100;
    end
    it.s[0] = sx; it.e[0] = ex; it.lo[0] = lo; it.hi[0] = hi;
    return it;
  endfunction

  task automatic run_random(int n);
    int burst;
    burst = 0;
    for (int j = 0; j < n; j++) begin
      if (burst == 0) begin
        idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
        burst = $urandom_range(1, 20);
      end
      burst--;
      send_item(random_item());
    end
    in_valid_i <= 0;
  endtask

  initial begin
    seg_box_t it;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: entries on both x faces and on a y and a z face, start inside,
    // entry at one, zero extent, inverted box and the coordinate extremes.
    send_item(box_item(-1000, 1000, -10, 10));
    send_item(box_item(1000, -1000, -10, 10));
    send_item(box_item(0, 1000, -10, 10));
    send_item(box_item(-1000, 0, 0, 10));
    send_item(box_item(-1000, 1000, 10, -10));
    send_item(box_item(-1000, 1000, 2000, 3000));
    it = box_item(5, 5, -10, 10);
    it.s[1] = -500; it.e[1] = 500; it.lo[1] = 50; it.hi[1] = 60;
    send_item(it);
    it = box_item(0, 0, -10, 10);
    it.s[2] = 500; it.e[2] = -500; it.lo[2] = -60; it.hi[2] = -50;
    send_item(it);
    send_item(box_item(32'sh7FFFFFFF, 32'sh80000000, -10, 10));
    send_item(box_item(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF));
    it = box_item(32'sh80000000, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF);
    for (int i = 1; i < 3; i++) begin
      it.s[i] = 32'sh80000000; it.e[i] = 32'sh7FFFFFFF;
      it.lo[i] = 32'sh80000000; it.hi[i] = 32'sh7FFFFFFF;
    end
    send_item(it);
    send_item(box_item(0, 1, -10, 10));
    send_item(box_item(-20, -19, -10, 10));
    in_valid_i <= 0;

    write_threshold(0);
    send_item(box_item(-20, -19, -10, 10));
    send_item(box_item(5, 5, -10, 10));
    write_threshold(16'hFFFF);
    send_item(box_item(-20000, 20000, -10, 10));
    send_item(box_item(-20000, 50000, -10, 10));
    run_random(90);

    write_threshold(0);
    run_random(90);
    write_threshold(1);
    run_random(90);
    write_threshold($urandom_range(2, 300));
    run_random(90);
    write_threshold($urandom_range(0, 16'hFFFF));
    run_random(90);

    while (sb.expected_hits.size() != 0) @(posedge clk_i);
    repeat (sbsh_pkg::DIV_LAT + 10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> sim.f
design/sbsh_pkg.sv
design/sbsh_div_step.sv
design/sbsh_divider.sv
design/sbsh_fold.sv
design/segment_box_slab_hit_unit.sv
dv/tb_top.sv
